// File: design/cbts_pkg.sv
`timescale 1ns / 1ps
package cbts_pkg;

   // field widths
   localparam int CLK_W      = 29;
   localparam int PERMILLE_W = 10;
   localparam int RATE_W     = 20;
   localparam int PRESC_W    = 10;
   localparam int SEG1_W     = 9;
   localparam int SEG2_W     = 8;
   localparam int JUMP_W     = 7;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 29;

   // parameter defaults
   localparam int MAX_PRESCALER_DEF = 512;
   localparam int SEG1_MAX_DEF      = 256;
   localparam int SEG2_MAX_DEF      = 128;

   // fixed constants of the timing rules
   localparam int PERMILLE_FULL       = 1000;
   localparam int FALLBACK_MIN_CLOCKS = 128;
   localparam int JUMP_LIMIT          = 127;
   localparam int FALLBACK_SHIFT      = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP           = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_MAX     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_MAX       = 3'd5;

   // register reset values
   localparam logic [CLK_W-1:0]      CLOCK_HZ_RST   = 29'd48000000;
   localparam logic [PERMILLE_W-1:0] SAMPLE_RST     = 10'd875;
   localparam logic [PERMILLE_W-1:0] JUMP_RST       = 10'd125;
   localparam logic [PERMILLE_W-1:0] SAMPLE_MIN_RST = 10'd500;
   localparam logic [PERMILLE_W-1:0] SAMPLE_MAX_RST = 10'd950;
   localparam logic [PERMILLE_W-1:0] JUMP_MAX_RST   = 10'd300;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } cbts_unit_stat_type;

endpackage

// File: design/cbts_serial_div.sv
`timescale 1ns / 1ps
module cbts_serial_div #(
   parameter int DW = 39,
   parameter int VW = 30
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [DW-1:0]                dividend,
   input  logic [VW-1:0]                divisor,
   output logic [DW-1:0]                quotient,
   output cbts_pkg::cbts_unit_stat_type stat
);
   import cbts_pkg::*;

   localparam int CW = (DW > 1) ? $clog2(DW) : 1;

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   rem_sh;
   logic [VW:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      diff    = rem_sh - {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go && !busy_ff) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[VW]) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: design/cbts_serial_mul.sv
`timescale 1ns / 1ps
module cbts_serial_mul #(
   parameter int AW = 29,
   parameter int BW = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [AW-1:0]                mcand,
   input  logic [BW-1:0]                mplier,
   output logic [AW+BW-1:0]             product,
   output cbts_pkg::cbts_unit_stat_type stat
);
   import cbts_pkg::*;

   localparam int CW = (BW > 1) ? $clog2(BW) : 1;

   logic [AW+BW-1:0] acc_ff, acc_in;
   logic [AW+BW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]    mplier_ff, mplier_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // shift and add, one multiplier bit per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (go && !busy_ff) begin
         acc_in    = '0;
         mcand_in  = {{BW{1'b0}}, mcand};
         mplier_in = mplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[AW+BW-2:0], 1'b0};
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: design/can_bit_timing_solver_unit.sv
`timescale 1ns / 1ps
// Each prescaler tried takes three serial divisions of 39-bit dividends, two serial
// multiplications by a 10-bit multiplier and the fix-up steps; n trials, n <= MAX_PRESCALER;
// a zero bit rate answers in the next cycle. One request at a time: busy stays high until
// the result. The divisions share one bit-serial divider, one quotient bit per cycle.
// Reset (synchronous, active high) idles the sequencer and loads the register defaults.
// The result strobe lasts one cycle; the receiver cannot stall.
module can_bit_timing_solver_unit #(
   parameter int MAX_PRESCALER = cbts_pkg::MAX_PRESCALER_DEF,
   parameter int SEG1_MAX      = cbts_pkg::SEG1_MAX_DEF,
   parameter int SEG2_MAX      = cbts_pkg::SEG2_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cbts_pkg::RATE_W-1:0]       req_bit_rate,
   output logic                              rsp_valid,
   output logic [cbts_pkg::PRESC_W-1:0]      rsp_prescaler,
   output logic [cbts_pkg::SEG1_W-1:0]       rsp_seg_one,
   output logic [cbts_pkg::SEG2_W-1:0]       rsp_seg_two,
   output logic [cbts_pkg::JUMP_W-1:0]       rsp_jump_width,
   output logic [cbts_pkg::WORD_W-1:0]       rsp_timing_word,
   output logic [cbts_pkg::CLK_W-1:0]        rsp_cpu_clocks_per_bit,
   output logic                              rsp_used_fallback,
   output logic                              rsp_bad_rate,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbts_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cbts_pkg::*;

   localparam int BRP_W = $clog2(MAX_PRESCALER + 1);
   localparam int PW    = RATE_W + BRP_W;
   localparam int DW    = CLK_W + PERMILLE_W;
   localparam int SW    = 32;

   localparam logic [BRP_W-1:0]       BRP_LAST  = BRP_W'(MAX_PRESCALER);
   localparam logic signed [SW-1:0]   SEG1_LIM  = SW'(SEG1_MAX);
   localparam logic signed [SW-1:0]   SEG2_LIM  = SW'(SEG2_MAX);
   localparam logic signed [SW-1:0]   JUMP_LIM  = SW'(JUMP_LIMIT);
   localparam logic signed [SW-1:0]   ONE_S     = SW'(1);
   localparam logic signed [SW-1:0]   TWO_S     = SW'(2);
   localparam logic [CLK_W-1:0]       BC_FLOOR  = CLK_W'(FALLBACK_MIN_CLOCKS);
   localparam logic [PERMILLE_W-1:0]  FULL_PM   = PERMILLE_W'(PERMILLE_FULL);

   typedef enum logic [3:0] {
      S_IDLE, S_BC_WAIT, S_MJ_WAIT, S_DJ_WAIT, S_MT_WAIT, S_DT_WAIT,
      S_SEG, S_FIX1, S_FIX2, S_CHECK, S_PACK
   } state_type;

   state_type             state_ff;

   // configuration registers
   logic [CLK_W-1:0]      clock_hz_ff;
   logic [PERMILLE_W-1:0] sample_ff, jump_ff, sample_min_ff, sample_max_ff, jump_max_ff;

   // per-request working registers
   logic [RATE_W-1:0]     rate_ff;
   logic [PW-1:0]         prod_ff;
   logic [BRP_W-1:0]      brp_ff;
   logic [PERMILLE_W-1:0] jmp_ff, m2_ff;
   logic [CLK_W-1:0]      bc_ff;
   logic signed [SW-1:0]  ts1_ff, ts2_ff, rjw_ff;
   logic                  fallback_ff;

   // unit operands and handshakes
   logic                  div_go_ff, mul_go_ff;
   logic [DW-1:0]         div_a_ff;
   logic [PW-1:0]         div_b_ff;
   logic [CLK_W-1:0]      mul_a_ff;
   logic [PERMILLE_W-1:0] mul_b_ff;
   logic [DW-1:0]         div_q;
   logic [DW-1:0]         mul_p;
   cbts_unit_stat_type    div_stat, mul_stat;

   // result registers
   logic                  rsp_valid_ff;
   logic [PRESC_W-1:0]    rsp_prescaler_ff;
   logic [SEG1_W-1:0]     rsp_seg_one_ff;
   logic [SEG2_W-1:0]     rsp_seg_two_ff;
   logic [JUMP_W-1:0]     rsp_jump_width_ff;
   logic [WORD_W-1:0]     rsp_timing_word_ff;
   logic [CLK_W-1:0]      rsp_cpb_ff;
   logic                  rsp_fallback_ff;
   logic                  rsp_bad_rate_ff;

   // combinational helpers
   logic [PERMILLE_W-1:0] smp_lo, smp_hi, smp_cl, jmp_cl;
   logic signed [SW-1:0]  q_s, q_min1, bc_s, bc_eighth;
   logic signed [SW-1:0]  s1_sat, s2_sat, j_sat;
   logic [BRP_W:0]        brp_m1;
   logic                  fits;

   function automatic logic signed [SW-1:0] sat_val(input logic signed [SW-1:0] v,
                                                   input logic signed [SW-1:0] hi);
      logic signed [SW-1:0] r;
      r = v;
      if (v < ONE_S) r = ONE_S;
      else if (v > hi) r = hi;
      return r;
   endfunction

   cbts_serial_div #(.DW(DW), .VW(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .quotient (div_q),
      .stat     (div_stat)
   );

   cbts_serial_mul #(.AW(CLK_W), .BW(PERMILLE_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go_ff),
      .mcand   (mul_a_ff),
      .mplier  (mul_b_ff),
      .product (mul_p),
      .stat    (mul_stat)
   );

   // clamp sample point and jump width for the incoming request
   always_comb begin
      smp_lo = (sample_ff < sample_min_ff) ? sample_min_ff : sample_ff;
      smp_hi = (smp_lo > sample_max_ff) ? sample_max_ff : smp_lo;
      smp_cl = (smp_hi > FULL_PM) ? FULL_PM : smp_hi;
      jmp_cl = (jump_ff > jump_max_ff) ? jump_max_ff : jump_ff;
   end

   // quotient and segment helpers
   always_comb begin
      q_s       = {1'b0, div_q[SW-2:0]};
      q_min1    = (q_s < ONE_S) ? ONE_S : q_s;
      bc_s      = SW'(bc_ff);
      bc_eighth = bc_s >>> FALLBACK_SHIFT;
      fits      = (ts1_ff >= ONE_S) && (ts1_ff <= SEG1_LIM) &&
                  (ts2_ff >= ONE_S) && (ts2_ff <= SEG2_LIM);
      s1_sat    = sat_val(ts1_ff, SEG1_LIM);
      s2_sat    = sat_val(ts2_ff, SEG2_LIM);
      j_sat     = sat_val(rjw_ff, JUMP_LIM);
      brp_m1    = {1'b0, brp_ff} - 1'b1;
   end

   // sequencer: search prescalers, hold state and registered outputs
   always_ff @(posedge clock) begin
      div_go_ff    <= 1'b0;
      mul_go_ff    <= 1'b0;
      rsp_valid_ff <= 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rate_ff <= req_bit_rate;
               if (req_bit_rate == '0) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_prescaler_ff   <= '0;
                  rsp_seg_one_ff     <= '0;
                  rsp_seg_two_ff     <= '0;
                  rsp_jump_width_ff  <= '0;
                  rsp_timing_word_ff <= '0;
                  rsp_cpb_ff         <= '0;
                  rsp_fallback_ff    <= 1'b0;
                  rsp_bad_rate_ff    <= 1'b1;
               end else begin
                  jmp_ff      <= jmp_cl;
                  m2_ff       <= FULL_PM - smp_cl;
                  brp_ff      <= BRP_W'(1);
                  prod_ff     <= PW'(req_bit_rate);
                  fallback_ff <= 1'b0;
                  div_a_ff    <= DW'(clock_hz_ff);
                  div_b_ff    <= PW'(req_bit_rate);
                  div_go_ff   <= 1'b1;
                  state_ff    <= S_BC_WAIT;
               end
            end
         end
         S_BC_WAIT: begin
            if (div_stat.done) begin
               bc_ff <= div_q[CLK_W-1:0];
               if (brp_ff == BRP_W'(1)) begin
                  rsp_cpb_ff <= div_q[CLK_W-1:0];
               end
               mul_a_ff  <= div_q[CLK_W-1:0];
               mul_b_ff  <= jmp_ff;
               mul_go_ff <= 1'b1;
               state_ff  <= S_MJ_WAIT;
            end
         end
         S_MJ_WAIT: begin
            if (mul_stat.done) begin
               div_a_ff  <= mul_p;
               div_b_ff  <= PW'(PERMILLE_FULL);
               div_go_ff <= 1'b1;
               state_ff  <= S_DJ_WAIT;
            end
         end
         S_DJ_WAIT: begin
            if (div_stat.done) begin
               rjw_ff    <= q_min1;
               mul_a_ff  <= bc_ff;
               mul_b_ff  <= m2_ff;
               mul_go_ff <= 1'b1;
               state_ff  <= S_MT_WAIT;
            end
         end
         S_MT_WAIT: begin
            if (mul_stat.done) begin
               div_a_ff  <= mul_p;
               div_b_ff  <= PW'(PERMILLE_FULL);
               div_go_ff <= 1'b1;
               state_ff  <= S_DT_WAIT;
            end
         end
         S_DT_WAIT: begin
            if (div_stat.done) begin
               ts2_ff   <= q_min1;
               state_ff <= S_SEG;
            end
         end
         S_SEG: begin
            ts1_ff   <= bc_s - rjw_ff - ts2_ff;
            state_ff <= S_FIX1;
         end
         // segment 1 too short: take the quantum from the jump width
         S_FIX1: begin
            if (ts1_ff < ONE_S) begin
               ts1_ff   <= ONE_S;
               rjw_ff   <= bc_s - ts2_ff - ONE_S;
               state_ff <= S_FIX2;
            end else begin
               state_ff <= S_CHECK;
            end
         end
         // jump width gone too: take it from segment 2
         S_FIX2: begin
            if (rjw_ff < ONE_S) begin
               rjw_ff <= ONE_S;
               ts2_ff <= bc_s - TWO_S;
            end
            state_ff <= S_CHECK;
         end
         S_CHECK: begin
            if (fits) begin
               state_ff <= S_PACK;
            end else if ((bc_ff >= BC_FLOOR) && (brp_ff < BRP_LAST)) begin
               brp_ff    <= brp_ff + 1'b1;
               prod_ff   <= prod_ff + PW'(rate_ff);
               div_a_ff  <= DW'(clock_hz_ff);
               div_b_ff  <= prod_ff + PW'(rate_ff);
               div_go_ff <= 1'b1;
               state_ff  <= S_BC_WAIT;
            end else begin
               fallback_ff <= 1'b1;
               ts2_ff      <= bc_eighth;
               rjw_ff      <= bc_eighth;
               ts1_ff      <= bc_s - (bc_eighth <<< 1);
               state_ff    <= S_PACK;
            end
         end
         S_PACK: begin
            rsp_valid_ff       <= 1'b1;
            rsp_prescaler_ff   <= PRESC_W'(SW'(brp_ff));
            rsp_seg_one_ff     <= s1_sat[SEG1_W-1:0];
            rsp_seg_two_ff     <= s2_sat[SEG2_W-1:0];
            rsp_jump_width_ff  <= j_sat[JUMP_W-1:0];
            rsp_timing_word_ff <= {j_sat[6:0], 9'(SW'(brp_m1)), 8'(s1_sat - ONE_S),
                                   1'b0, 7'(s2_sat - ONE_S)};
            rsp_fallback_ff    <= fallback_ff;
            rsp_bad_rate_ff    <= 1'b0;
            state_ff           <= S_IDLE;
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff   <= CLOCK_HZ_RST;
         sample_ff     <= SAMPLE_RST;
         jump_ff       <= JUMP_RST;
         sample_min_ff <= SAMPLE_MIN_RST;
         sample_max_ff <= SAMPLE_MAX_RST;
         jump_max_ff   <= JUMP_MAX_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_HZ:   clock_hz_ff   <= csr_data;
            CSR_SAMPLE:     sample_ff     <= csr_data[PERMILLE_W-1:0];
            CSR_JUMP:       jump_ff       <= csr_data[PERMILLE_W-1:0];
            CSR_SAMPLE_MIN: sample_min_ff <= csr_data[PERMILLE_W-1:0];
            CSR_SAMPLE_MAX: sample_max_ff <= csr_data[PERMILLE_W-1:0];
            CSR_JUMP_MAX:   jump_max_ff   <= csr_data[PERMILLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready              = 1'b1;
   assign busy                   = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_prescaler          = rsp_prescaler_ff;
   assign rsp_seg_one            = rsp_seg_one_ff;
   assign rsp_seg_two            = rsp_seg_two_ff;
   assign rsp_jump_width         = rsp_jump_width_ff;
   assign rsp_timing_word        = rsp_timing_word_ff;
   assign rsp_cpu_clocks_per_bit = rsp_cpb_ff;
   assign rsp_used_fallback      = rsp_fallback_ff;
   assign rsp_bad_rate           = rsp_bad_rate_ff;

`ifndef SYNTH
   // a zero rate is answered at once with the flag
   a_bad_rate: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_bit_rate == '0)) |=> (rsp_valid && rsp_bad_rate))
      else $error("zero bit rate not answered in one cycle");

   // the arithmetic units only run while a request is in progress
   a_units_busy: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || mul_stat.busy) |-> busy)
      else $error("arithmetic unit running while idle");

   // a solved result never carries zero segments or jump width
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_rate) |->
      ((rsp_seg_one != '0) && (rsp_seg_two != '0) && (rsp_jump_width != '0)))
      else $error("solved result with zero segment");

   // a solved result follows a busy period
   a_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_rate) |-> $past(busy))
      else $error("result without a request in progress");
`endif

endmodule
